### design/rtp_pkg.sv
// Shared types, codes and limit tables for the radix integer text parser.
package rtp_pkg;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    localparam logic [2:0] TYPE_SHORT  = 3'd0;
    localparam logic [2:0] TYPE_USHORT = 3'd1;
    localparam logic [2:0] TYPE_INT    = 3'd2;
    localparam logic [2:0] TYPE_UINT   = 3'd3;
    localparam logic [2:0] TYPE_LONG   = 3'd4;
    localparam logic [2:0] TYPE_ULONG  = 3'd5;

    localparam logic [1:0] CFG_RADIX = 2'd0;
    localparam logic [1:0] CFG_TYPE  = 2'd1;
    localparam logic [1:0] CFG_SKIP  = 2'd2;

    localparam logic [1:0] LIMCLS_S16 = 2'd0;
    localparam logic [1:0] LIMCLS_U16 = 2'd1;
    localparam logic [1:0] LIMCLS_S32 = 2'd2;
    localparam logic [1:0] LIMCLS_U32 = 2'd3;

    localparam logic [31:0] LIM_S16 = 32'd32767;
    localparam logic [31:0] LIM_U16 = 32'd65535;
    localparam logic [31:0] LIM_S32 = 32'd2147483647;
    localparam logic [31:0] LIM_U32 = 32'hFFFF_FFFF;

    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_SPACE = 16'h0020;

    typedef struct packed {
        logic [1:0] radix;
        logic [2:0] itype;
        logic       skip_ws;
    } t_cfg;

    typedef struct packed {
        logic       skip;
        logic       sign;
        logic       minus;
        logic       dig_ok;
        logic [3:0] dig;
    } t_cls;

    function automatic logic [1:0] limit_class(input logic [2:0] t);
        case (t) inside
            TYPE_SHORT, TYPE_LONG: return LIMCLS_S16;
            TYPE_INT:              return LIMCLS_S32;
            TYPE_UINT:             return LIMCLS_U32;
            default:               return LIMCLS_U16;
        endcase
    endfunction

    function automatic logic is_signed_type(input logic [2:0] t);
        return (t == TYPE_SHORT) || (t == TYPE_INT) || (t == TYPE_LONG);
    endfunction

    function automatic logic [4:0] radix_value(input logic [1:0] m);
        case (m)
            RADIX_HEX: return 5'd16;
            RADIX_OCT: return 5'd8;
            default:   return 5'd10;
        endcase
    endfunction

    function automatic logic [31:0] max_by(input logic [1:0] k, input logic [1:0] m);
        case (k)
            LIMCLS_S16: begin
                case (m)
                    RADIX_HEX: return LIM_S16 / 16;
                    RADIX_OCT: return LIM_S16 / 8;
                    default:   return LIM_S16 / 10;
                endcase
            end
            LIMCLS_U16: begin
                case (m)
                    RADIX_HEX: return LIM_U16 / 16;
                    RADIX_OCT: return LIM_U16 / 8;
                    default:   return LIM_U16 / 10;
                endcase
            end
            LIMCLS_S32: begin
                case (m)
                    RADIX_HEX: return LIM_S32 / 16;
                    RADIX_OCT: return LIM_S32 / 8;
                    default:   return LIM_S32 / 10;
                endcase
            end
            default: begin
                case (m)
                    RADIX_HEX: return LIM_U32 / 16;
                    RADIX_OCT: return LIM_U32 / 8;
                    default:   return LIM_U32 / 10;
                endcase
            end
        endcase
    endfunction

    function automatic logic [3:0] max_mod(input logic [1:0] k, input logic [1:0] m);
        case (k)
            LIMCLS_S16: begin
                case (m)
                    RADIX_HEX: return 4'(LIM_S16 % 16);
                    RADIX_OCT: return 4'(LIM_S16 % 8);
                    default:   return 4'(LIM_S16 % 10);
                endcase
            end
            LIMCLS_U16: begin
                case (m)
                    RADIX_HEX: return 4'(LIM_U16 % 16);
                    RADIX_OCT: return 4'(LIM_U16 % 8);
                    default:   return 4'(LIM_U16 % 10);
                endcase
            end
            LIMCLS_S32: begin
                case (m)
                    RADIX_HEX: return 4'(LIM_S32 % 16);
                    RADIX_OCT: return 4'(LIM_S32 % 8);
                    default:   return 4'(LIM_S32 % 10);
                endcase
            end
            default: begin
                case (m)
                    RADIX_HEX: return 4'(LIM_U32 % 16);
                    RADIX_OCT: return 4'(LIM_U32 % 8);
                    default:   return 4'(LIM_U32 % 10);
                endcase
            end
        endcase
    endfunction

endpackage

### design/rtp_front.sv
// Front end: configuration registers, input handshake and character classification.
module rtp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_q_full,
    output logic              o_push,
    output rtp_pkg::t_cls     o_cls,
    output rtp_pkg::t_cfg     o_cfg
);
    import rtp_pkg::*;

    t_cfg        r_cfg;
    logic [15:0] w_ch;
    logic        w_eos;
    logic        w_blank;
    logic        w_is_dig;
    logic [3:0]  w_dv;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_s_tready  = !i_q_full;
    assign o_push      = i_s_tvalid && !i_q_full;
    assign w_ch        = i_s_tdata;
    assign w_eos       = i_s_tuser;

    always_comb begin
        w_is_dig = 1'b0;
        w_dv     = 4'd0;
        if (w_ch >= 16'h0030 && w_ch <= 16'h0039) begin
            w_is_dig = 1'b1;
            w_dv     = w_ch[3:0];
        end else if ((w_ch >= 16'h0061 && w_ch <= 16'h0066)
                  || (w_ch >= 16'h0041 && w_ch <= 16'h0046)) begin
            w_is_dig = 1'b1;
            w_dv     = w_ch[3:0] + 4'd9;
        end
        w_blank = (w_ch == CH_SPACE) || (w_ch >= 16'h0009 && w_ch <= 16'h000D);

        o_cls.skip   = !w_eos && r_cfg.skip_ws && w_blank;
        o_cls.sign   = !w_eos && is_signed_type(r_cfg.itype)
                    && ((w_ch == CH_PLUS) || (w_ch == CH_MINUS));
        o_cls.minus  = (w_ch == CH_MINUS);
        o_cls.dig_ok = !w_eos && w_is_dig && ({1'b0, w_dv} < radix_value(r_cfg.radix));
        o_cls.dig    = w_dv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix   <= RADIX_DEC;
            r_cfg.itype   <= TYPE_INT;
            r_cfg.skip_ws <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX: r_cfg.radix   <= i_cfg_data[1:0];
                CFG_TYPE:  r_cfg.itype   <= i_cfg_data;
                CFG_SKIP:  r_cfg.skip_ws <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

endmodule

### design/rtp_queue.sv
// Two-entry queue of classified characters between the front and back ends.
module rtp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rtp_pkg::t_cls i_data,
    output logic          o_full,
    output logic          o_valid,
    output rtp_pkg::t_cls o_data,
    input  logic          i_pop
);
    import rtp_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

### design/rtp_back.sv
// Back end: parse state machine, digit accumulation, limit check and result register.
module rtp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rtp_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  rtp_pkg::t_cls i_cls,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,
    output logic [1:0]    o_m_tuser
);
    import rtp_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_SIGN, PH_DIGITS} t_phase;

    t_phase      r_phase;
    logic [31:0] r_acc;
    logic        r_neg;
    logic [3:0]  r_used;
    logic        r_m_valid;
    logic [31:0] r_value;
    logic [3:0]  r_chars;
    logic        r_failed;
    logic        r_stopped;

    logic [31:0] w_max_by;
    logic [3:0]  w_max_mod;
    logic [1:0]  w_cls;
    logic        w_in_range;
    logic [31:0] w_scaled;
    logic [31:0] w_next;
    logic [31:0] w_signed_val;
    logic        w_emit;

    assign o_pop      = i_q_valid && (!r_m_valid || i_m_tready);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_chars, r_value};
    assign o_m_tuser  = {r_stopped, r_failed};

    always_comb begin
        w_cls      = limit_class(i_cfg.itype);
        w_max_by   = max_by(w_cls, i_cfg.radix);
        w_max_mod  = max_mod(w_cls, i_cfg.radix);
        w_in_range = (r_acc < w_max_by) || ((r_acc == w_max_by) && (i_cls.dig <= w_max_mod));
        case (i_cfg.radix)
            RADIX_HEX: w_scaled = {r_acc[27:0], 4'd0};
            RADIX_OCT: w_scaled = {r_acc[28:0], 3'd0};
            default:   w_scaled = {r_acc[28:0], 3'd0} + {r_acc[30:0], 1'b0};
        endcase
        w_next       = w_scaled + {28'd0, i_cls.dig};
        w_signed_val = r_neg ? (32'd0 - r_acc) : r_acc;
        w_emit       = 1'b0;
        if (o_pop && (r_phase == PH_DIGITS)) begin
            w_emit = !(i_cls.dig_ok && w_in_range);
        end else if (o_pop && ((r_phase == PH_START) || (r_phase == PH_SIGN))) begin
            w_emit = !((r_phase == PH_START) && (i_cls.skip || i_cls.sign)) && !i_cls.dig_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_acc     <= 32'd0;
            r_neg     <= 1'b0;
            r_used    <= 4'd0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (r_phase) inside
                    PH_START, PH_SIGN: begin
                        if (r_phase == PH_START && i_cls.skip) begin
                            r_phase <= PH_START;
                        end else if (r_phase == PH_START && i_cls.sign) begin
                            r_neg   <= i_cls.minus;
                            r_used  <= 4'd1;
                            r_phase <= PH_SIGN;
                        end else if (i_cls.dig_ok) begin
                            r_acc   <= {28'd0, i_cls.dig};
                            r_used  <= r_used + 4'd1;
                            r_phase <= PH_DIGITS;
                        end else begin
                            r_value   <= 32'd0;
                            r_chars   <= 4'd0;
                            r_failed  <= 1'b1;
                            r_stopped <= 1'b0;
                            r_phase   <= PH_START;
                            r_acc     <= 32'd0;
                            r_neg     <= 1'b0;
                            r_used    <= 4'd0;
                        end
                    end
                    PH_DIGITS: begin
                        if (i_cls.dig_ok && w_in_range) begin
                            r_acc <= w_next;
                            if (r_used != 4'd15) begin
                                r_used <= r_used + 4'd1;
                            end
                        end else begin
                            r_value   <= w_signed_val;
                            r_chars   <= r_used;
                            r_failed  <= 1'b0;
                            r_stopped <= i_cls.dig_ok;
                            r_phase   <= PH_START;
                            r_acc     <= 32'd0;
                            r_neg     <= 1'b0;
                            r_used    <= 4'd0;
                        end
                    end
                    default: r_phase <= PH_START;
                endcase
            end
        end
    end

endmodule

### design/radix_integer_text_parser.sv
// Top level of the radix integer text parser.
// Parses integers in decimal, hexadecimal or octal from a stream of 16-bit characters,
// one character per beat, and sends one result beat when a number ends; the ending
// character is consumed and not reread. The block sustains one input beat per clock; a
// result beat waits in an output register while input continues into the two-entry
// queue, and input stalls only when both the queue and the output register are full.
// The ending character is registered in the queue and then in the output register
// before its result beat is sent. Configuration is meant to be written only while
// no character is waiting inside the block; a number that is half read carries on
// under the new settings.
module radix_integer_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] char_code
    input  logic        i_s_tuser,   // [0] end_of_stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] value_bits, [35:32] chars_used, [39:36] zero
    output logic [1:0]  o_m_tuser    // [0] parse_failed, [1] stopped_by_limit
);
    import rtp_pkg::*;

    t_cfg w_cfg;
    t_cls w_front_cls;
    t_cls w_q_cls;
    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;

    rtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cls       (w_front_cls),
        .o_cfg       (w_cfg)
    );

    rtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cls),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cls),
        .i_pop   (w_pop)
    );

    rtp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_cls      (w_q_cls),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### tb/rtp_checker.sv
// Watches the parser's channels, predicts every number it should produce and checks each result beat.
module rtp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] char_code
    input  logic        i_s_tuser,   // [0] end_of_stream
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [31:0] value_bits, [35:32] chars_used, [39:36] zero
    input  logic [1:0]  i_m_tuser,   // [0] parse_failed, [1] stopped_by_limit
    output int          o_fail_count,
    output int          o_pending,
    output int          o_numbers_checked
);
    import rtp_pkg::*;

    localparam logic [4:0] NOT_A_DIGIT = 5'd31;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGNED = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] value;
        logic        failed;
        logic [3:0]  used;
        logic        stopped;
    } t_number;

    t_number     pending_numbers[$];

    logic [1:0]  cfg_radix;
    logic [2:0]  cfg_type;
    logic        cfg_skip;

    t_phase      phase;
    logic [31:0] acc;
    logic        neg;
    logic [3:0]  used;

    int          fails;
    int          checked;

    function automatic logic [4:0] base_of(input logic [1:0] m);
        case (m)
            RADIX_HEX: return 5'd16;
            RADIX_OCT: return 5'd8;
            default:   return 5'd10;
        endcase
    endfunction

    function automatic logic [31:0] ceiling_of(input logic [2:0] t);
        case (t) inside
            TYPE_SHORT, TYPE_LONG: return LIM_S16;
            TYPE_INT:              return LIM_S32;
            TYPE_UINT:             return LIM_U32;
            default:               return LIM_U16;
        endcase
    endfunction

    function automatic logic [4:0] digit_value(input logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return 5'(c - 16'h0030);
        if (c >= 16'h0061 && c <= 16'h0066) return 5'(c - 16'h0061 + 16'd10);
        if (c >= 16'h0041 && c <= 16'h0046) return 5'(c - 16'h0041 + 16'd10);
        return NOT_A_DIGIT;
    endfunction

    function automatic logic is_blank(input logic [15:0] c);
        return (c == CH_SPACE) || (c >= 16'h0009 && c <= 16'h000D);
    endfunction

    task automatic clear_number();
        phase = PH_START;
        acc   = 32'd0;
        neg   = 1'b0;
        used  = 4'd0;
    endtask

    task automatic finish_number(input logic failed, input logic stopped);
        t_number n;
        n.value   = failed ? 32'd0 : (neg ? 32'd0 - acc : acc);
        n.failed  = failed;
        n.used    = failed ? 4'd0 : used;
        n.stopped = !failed && stopped;
        pending_numbers.push_back(n);
        clear_number();
    endtask

    task automatic parse_char(input logic [15:0] ch, input logic eos);
        logic [4:0]  base;
        logic [31:0] lim;
        logic [31:0] quot;
        logic [4:0]  rem;
        logic [4:0]  d;
        logic        signed_type;
        base        = base_of(cfg_radix);
        lim         = ceiling_of(cfg_type);
        quot        = lim / base;
        rem         = 5'(lim % base);
        signed_type = (cfg_type == TYPE_SHORT) || (cfg_type == TYPE_INT) ||
                      (cfg_type == TYPE_LONG);
        d           = eos ? NOT_A_DIGIT : digit_value(ch);
        if (phase == PH_START) begin
            if (!eos && cfg_skip && is_blank(ch)) return;
            if (!eos && signed_type && (ch == CH_MINUS || ch == CH_PLUS)) begin
                neg   = (ch == CH_MINUS);
                used  = 4'd1;
                phase = PH_SIGNED;
                return;
            end
        end
        if (phase != PH_DIGITS) begin
            if (d < base) begin
                acc   = 32'(d);
                used  = used + 4'd1;
                phase = PH_DIGITS;
            end else begin
                finish_number(1'b1, 1'b0);
            end
            return;
        end
        if (d < base) begin
            if (acc < quot || (acc == quot && d <= rem)) begin
                acc = acc * 32'(base) + 32'(d);
                if (used != 4'hF) used = used + 4'd1;
            end else begin
                finish_number(1'b0, 1'b1);
            end
        end else begin
            finish_number(1'b0, 1'b0);
        end
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic check_number();
        t_number want;
        if (pending_numbers.size() == 0) begin
            fails++;
            $display("%0t: result beat with nothing expected, actual tdata %0h tuser %0h",
                     $time, i_m_tdata, i_m_tuser);
            return;
        end
        want = pending_numbers.pop_front();
        checked++;
        if (i_m_tdata[31:0] !== want.value) report("value_bits", want.value, i_m_tdata[31:0]);
        if (i_m_tuser[0] !== want.failed) report("parse_failed", 32'(want.failed), 32'(i_m_tuser[0]));
        if (i_m_tdata[35:32] !== want.used) report("chars_used", 32'(want.used), 32'(i_m_tdata[35:32]));
        if (i_m_tuser[1] !== want.stopped) begin
            report("stopped_by_limit", 32'(want.stopped), 32'(i_m_tuser[1]));
        end
        if (i_m_tdata[39:36] !== 4'd0) report("tdata padding", 32'd0, 32'(i_m_tdata[39:36]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_radix = RADIX_DEC;
            cfg_type  = TYPE_INT;
            cfg_skip  = 1'b1;
            clear_number();
            pending_numbers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIX: cfg_radix = i_cfg_data[1:0];
                    CFG_TYPE:  cfg_type  = i_cfg_data;
                    CFG_SKIP:  cfg_skip  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) parse_char(i_s_tdata, i_s_tuser);
            if (i_m_tvalid && i_m_tready) check_number();
        end
        o_fail_count      <= fails;
        o_pending         <= pending_numbers.size();
        o_numbers_checked <= checked;
    end

endmodule

### tb/tb_radix_integer_text_parser.sv
// Testbench top for the radix integer text parser: clock, reset, stimulus and verdict.
module tb_radix_integer_text_parser;
    import rtp_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam logic [1:0] RADIX_SPARE   = 2'd3;
    localparam logic [2:0] TYPE_SPARE_HI = 3'd7;
    localparam logic [2:0] TYPE_SPARE_LO = 3'd6;
    localparam int         RANDOM_ITEMS  = 1400;
    localparam int         CALM_ITEMS    = 150;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_RADIX;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        i_s_tvalid = 1'b0;
    logic [15:0] i_s_tdata = 16'd0;
    logic        i_s_tuser = 1'b0;
    logic        i_m_tready = 1'b1;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int          fail_count;
    int          pending;
    int          numbers_checked;

    int          cycles = 0;
    int          items = 0;
    int          cfg_rounds = 0;
    int          cur_base = 10;
    logic [2:0]  cur_type = TYPE_INT;
    logic        calm = 1'b0;
    logic        gaps_on = 1'b1;
    logic        stall_on = 1'b1;
    int          stall_left = 0;

    always #5 i_clk = ~i_clk;

    radix_integer_text_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    rtp_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tuser         (i_s_tuser),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tuser         (o_m_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_numbers_checked (numbers_checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The result side stalls in bursts, and whole stretches run with no stalls at all.
    always @(posedge i_clk) begin
        if (cycles % 200 == 0) stall_on <= ($urandom_range(0, 2) != 0);
        if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] digit_char(input int d, input bit upper);
        if (d < 10) return 16'(16'h0030 + d);
        return 16'((upper ? 16'h0041 : 16'h0061) + d - 10);
    endfunction

    function automatic logic [31:0] type_ceiling(input logic [2:0] t);
        case (t) inside
            TYPE_SHORT, TYPE_LONG: return LIM_S16;
            TYPE_INT:              return LIM_S32;
            TYPE_UINT:             return LIM_U32;
            default:               return LIM_U16;
        endcase
    endfunction

    task automatic put_char(input logic [15:0] ch, input logic eos);
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= eos;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items++;
        if (items % 97 == 0) gaps_on = ($urandom_range(0, 2) != 0);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) put_char(16'(s[k]), 1'b0);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] radix, input logic [2:0] itype, input logic skip,
                              input bit poke_spare);
        logic [2:0] data;
        data    = {1'b0, radix};
        data[2] = 1'($urandom_range(0, 1));
        write_reg(CFG_RADIX, data);
        write_reg(CFG_TYPE, itype);
        data    = {2'(32'($urandom_range(0, 3))), skip};
        write_reg(CFG_SKIP, data);
        if (poke_spare) write_reg(CFG_SPARE, 3'(32'($urandom_range(0, 7))));
        i_cfg_valid <= 1'b0;
        cur_base = (radix == RADIX_HEX) ? 16 : (radix == RADIX_OCT) ? 8 : 10;
        cur_type = itype;
        cfg_rounds++;
    endtask

    task automatic put_blank();
        int v;
        v = $urandom_range(0, 5);
        put_char(v == 5 ? CH_SPACE : 16'(9 + v), 1'b0);
    endtask

    task automatic put_stop();
        case ($urandom_range(0, 6))
            0: put_char(16'($urandom_range(0, 65535)), 1'b1);
            1: put_char(CH_SPACE, 1'b0);
            2: put_char(16'h002C, 1'b0);
            3: put_char(16'hFFFF, 1'b0);
            4: put_char(16'($urandom_range(0, 65535)), 1'b0);
            5: put_char($urandom_range(0, 1) ? 16'h0047 : 16'h0067, 1'b0);
            default: ;
        endcase
    endtask

    task automatic put_sign();
        if ($urandom_range(0, 1)) put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
    endtask

    task automatic send_number();
        int n;
        repeat ($urandom_range(0, 2)) put_blank();
        put_sign();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 1);
        repeat (n) put_char(16'h0030, 1'b0);
        repeat ($urandom_range(1, 10)) begin
            n = ($urandom_range(0, 2) == 0) ? cur_base - 1 : $urandom_range(0, cur_base - 1);
            put_char(digit_char(n, 1'($urandom_range(0, 1))), 1'b0);
        end
        put_stop();
    endtask

    // Spells the type's ceiling in the current base, then either stops there, alters
    // the last digit or adds one more digit, so both sides of the limit are reached.
    task automatic send_ceiling();
        int          digits[$];
        logic [31:0] lim;
        int          variant;
        lim = type_ceiling(cur_type);
        while (lim != 0) begin
            digits.push_front(int'(lim % cur_base));
            lim = lim / cur_base;
        end
        variant = $urandom_range(0, 2);
        if (variant == 1) digits[digits.size() - 1] = $urandom_range(0, cur_base - 1);
        if (variant == 2) digits.push_back($urandom_range(0, cur_base - 1));
        put_sign();
        foreach (digits[k]) put_char(digit_char(digits[k], 1'($urandom_range(0, 1))), 1'b0);
        put_stop();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 4))
                0: put_char(16'($urandom_range(0, 65535)), 1'b0);
                1: put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
                2: put_char(16'($urandom_range(0, 65535)), 1'b1);
                3: put_char(16'($urandom_range(0, 127)), 1'b0);
                default: put_blank();
            endcase
        end
    endtask

    initial begin
        int spread;
        int kind;
        spread = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings: decimal int with blanks skipped.
        put_char(16'hFFFF, 1'b1);
        send_text(" \t+x");
        send_text("-7");
        put_char(16'hFFFF, 1'b0);
        // Settings change while a number is half read.
        send_text("12");
        wait_drained();
        set_config(RADIX_HEX, TYPE_INT, 1'b1, 1'b1);
        send_text("a");
        put_char(16'h0000, 1'b1);
        wait_drained();
        set_config(RADIX_DEC, TYPE_USHORT, 1'b0, 1'b0);
        send_text(" 65536");
        wait_drained();
        set_config(RADIX_HEX, TYPE_UINT, 1'b1, 1'b0);
        send_text("-Ab");
        put_char(16'h0000, 1'b0);
        wait_drained();
        set_config(RADIX_OCT, TYPE_SPARE_LO, 1'b1, 1'b0);
        send_text("7778");
        wait_drained();
        set_config(RADIX_SPARE, TYPE_SPARE_HI, 1'b1, 1'b0);
        send_text("9");
        put_char(16'h0000, 1'b1);

        // Random part: mostly well-formed numbers, some near the limits, the rest noise.
        while (items < RANDOM_ITEMS) begin
            if (!calm && items >= RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
            if (!calm && $urandom_range(0, 14) == 0) begin
                wait_drained();
                set_config(2'(32'($urandom_range(0, 3))),
                           spread < 8 ? 3'(spread) : 3'(32'($urandom_range(0, 7))),
                           1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
                spread++;
            end
            kind = $urandom_range(0, 9);
            if (kind < 6) send_number();
            else if (kind < 8) send_ceiling();
            else send_noise();
        end
        put_char(16'h0000, 1'b1);
        wait_drained();

        $display("Sent %0d characters under %0d register settings; %0d numbers checked.",
                 items, cfg_rounds, numbers_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
